// ===== rtl/escape_time_color_palette_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time color palette
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_COLOR_PALETTE_MACROS_SVH
`define ESCAPE_TIME_COLOR_PALETTE_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define ETCP_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define ETCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/etcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Escape-time color palette package
// Register indexes, fixed colors and channel constants of both palettes.
// ----------------------------------------------------------------------------
package etcp_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_ITER_LIMIT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PALETTE    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INTERIOR   = 2'd2;

  // Reset values
  localparam logic [15:0] ITER_LIMIT_RST = 16'd100;
  localparam logic [31:0] INTERIOR_RST   = 32'h0000_00FF;

  // Interior color of the sine wave palette
  localparam logic [31:0] UV_INTERIOR = 32'h0A0A_2EFF;

  // Quarter-wave sine table: pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int SINE_MAX = 32767;

  // Smooth polynomial palette: gains (Q16) and offsets
  localparam logic [15:0] P0_GAIN_R = 16'd1620;
  localparam logic [15:0] P0_GAIN_G = 16'd2250;
  localparam logic [15:0] P0_GAIN_B = 16'd4335;
  localparam logic [15:0] P0_OFS_R  = 16'd75;
  localparam logic [15:0] P0_OFS_B  = 16'd100;
  localparam logic [15:0] HALF_Q16  = 16'h8000;

  // Sine wave palette: base levels and amplitudes
  localparam logic [7:0]  P1_BASE_R = 8'd128;
  localparam logic [7:0]  P1_BASE_G = 8'd64;
  localparam logic [7:0]  P1_BASE_B = 8'd200;
  localparam logic [21:0] P1_AMP_R  = 22'd70;
  localparam logic [21:0] P1_AMP_G  = 22'd40;
  localparam logic [21:0] P1_AMP_B  = 22'd55;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] CHAN_MAX     = 8'hFF;

endpackage

// ===== rtl/escape_time_color_palette.sv =====
// ----------------------------------------------------------------------------
// Escape-time color palette
// Maps a fractal iteration count to a packed RGBA pixel, one pixel a clock while out_tready stays high.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one iteration count per transfer in in_tdata.
//   Output stream (out_*): one RGBA pixel per input, in order, in out_tdata.
//   Config port (cfg_*): write iteration_limit (0), palette_select (1) and
//   interior_color (2) while no pixel is in flight; other indexes are ignored.
// Throughput: one pixel per clock unless out_tready stalls the output. Every stage holds a valid
//   bit and moves on whenever the stage after it is empty or moving, so bubbles collapse.
// Pipeline: the count/limit divider retires two quotient bits per stage; the
//   other stages are input capture, phase scaling, quadrant fold, sine table
//   read, three multiplier levels and the output register.
// Reset: empties the pipeline and loads limit 100, palette 0 and interior
//   color 0x000000FF. The sine table is constant; no fill pass is needed.
// Stall: a held out_tready freezes the output register; the pipeline keeps
//   taking input until every stage is full, then drops in_tready.
// ----------------------------------------------------------------------------
`include "escape_time_color_palette_macros.svh"

module escape_time_color_palette
  import etcp_pkg::*;
#(
  parameter int COUNT_BITS       = 16,
  parameter int FRACTION_BITS    = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Input stream; tdata[COUNT_BITS-1:0] = iteration_count, rest zero
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((COUNT_BITS+7)/8)*8-1:0]         in_tdata,
  // Output stream; tdata[31:0] = pixel_rgba
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [31:0]                             out_tdata,
  // Configuration write port
  input  logic                                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]                   cfg_addr,
  input  logic [CFG_DATA_W-1:0]                   cfg_wdata
);

  localparam int CB         = COUNT_BITS;
  localparam int FB         = FRACTION_BITS;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (FB + DIV_STEP - 1) / DIV_STEP;
  localparam int PH_W       = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int AW         = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W     = FB + PH_W;

  // Stage positions
  localparam int S_PH   = DIV_STAGES + 1;
  localparam int S_ADDR = DIV_STAGES + 2;
  localparam int S_ROM  = DIV_STAGES + 3;
  localparam int S_M1   = DIV_STAGES + 4;
  localparam int S_M2   = DIV_STAGES + 5;
  localparam int S_M3   = DIV_STAGES + 6;
  localparam int S_OUT  = DIV_STAGES + 7;
  localparam int NSTG   = DIV_STAGES + 8;

  localparam logic [CB-1:0]   LIM_MASK = CB'(17'h0FFFF);
  localparam logic [PH_W-1:0] QD1      = PH_W'(SINE_TABLE_DEPTH);
  localparam logic [PH_W-1:0] QD2      = PH_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [PH_W-1:0] QD3      = PH_W'(3 * SINE_TABLE_DEPTH);

  // Quarter-wave sine entry in Q1.15 by an integer Taylor series in Q30
  function automatic logic [14:0] sine_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint unsigned e;
    x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      case (n)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        default: term = term / 110;
      endcase
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = (longint'(sum) + 16384) >> 15;
    if (e > SINE_MAX) begin
      e = SINE_MAX;
    end
    return e[14:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CB-1:0] lim_r;
  logic          pal_r;
  logic [31:0]   icolor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r    <= CB'(ITER_LIMIT_RST) & LIM_MASK;
      pal_r    <= 1'b0;
      icolor_r <= INTERIOR_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ITER_LIMIT: lim_r    <= cfg_wdata[CB-1:0] & LIM_MASK;
        REG_PALETTE:    pal_r    <= cfg_wdata[0];
        REG_INTERIOR:   icolor_r <= cfg_wdata[31:0];
        default:        ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its content moves on
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  assign en[NSTG-1] = ~vld_r[NSTG-1] | out_tready;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
    assign en[k] = ~vld_r[k] | en[k+1];
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NSTG-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Interior flag travels with each pixel up to the last multiplier stage
  logic int_r [S_OUT];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      int_r[0] <= (in_tdata[CB-1:0] >= lim_r);
    end
    for (int k = 1; k < S_OUT; k++) begin
      if (en[k]) begin
        int_r[k] <= int_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: t = (count << FB) / limit, two quotient bits per stage
  // --------------------------------------------------------------------------
  logic [CB-1:0] rem_r [DIV_STAGES+1];
  logic [FB-1:0] quo_r [1:DIV_STAGES];

  // Capture the count as the starting remainder
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= in_tdata[CB-1:0];
    end
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    logic [FB-1:0] quo_in;
    logic [CB-1:0] rem_nxt;
    logic [FB-1:0] quo_nxt;

    if (s == 1) begin : g_first
      assign quo_in = '0;
    end else begin : g_rest
      assign quo_in = quo_r[s-1];
    end

    // Shift, trial subtract, record quotient bit
    always_comb begin
      logic [CB:0] trial;
      rem_nxt = rem_r[s-1];
      quo_nxt = quo_in;
      for (int b = 0; b < DIV_STEP; b++) begin
        if ((s - 1) * DIV_STEP + b < FB) begin
          trial = {rem_nxt, 1'b0};
          if (trial >= {1'b0, lim_r}) begin
            trial   = trial - {1'b0, lim_r};
            quo_nxt = {quo_nxt[FB-2:0], 1'b1};
          end else begin
            quo_nxt = {quo_nxt[FB-2:0], 1'b0};
          end
          rem_nxt = trial[CB-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Phase: t scaled to half a circle (palette 0) or a full circle (palette 1)
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] ph_prod;
  logic [PROD_W-1:0] ph_full;
  logic [PH_W-1:0]   phase_nxt;
  logic [PH_W-1:0]   phase_r;

  assign ph_prod   = PROD_W'(quo_r[DIV_STAGES]) * PROD_W'(SINE_TABLE_DEPTH);
  assign ph_full   = pal_r ? (ph_prod << 2) : (ph_prod << 1);
  assign phase_nxt = ph_full[FB +: PH_W];

  always_ff @(posedge clk) begin
    if (en[S_PH]) begin
      phase_r <= phase_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Quadrant fold into a table address and a sign
  // --------------------------------------------------------------------------
  logic [1:0]      quad;
  logic [PH_W-1:0] qbase;
  logic [PH_W-1:0] qofs;
  logic [AW-1:0]   addr_nxt;
  logic [AW-1:0]   addr_r;
  logic            sign_a_r;

  always_comb begin
    if (phase_r >= QD3) begin
      quad  = 2'd3;
      qbase = QD3;
    end else if (phase_r >= QD2) begin
      quad  = 2'd2;
      qbase = QD2;
    end else if (phase_r >= QD1) begin
      quad  = 2'd1;
      qbase = QD1;
    end else begin
      quad  = 2'd0;
      qbase = '0;
    end
    qofs     = phase_r - qbase;
    addr_nxt = quad[0] ? AW'(SINE_TABLE_DEPTH) - qofs[AW-1:0] : qofs[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[S_ADDR]) begin
      addr_r   <= addr_nxt;
      sign_a_r <= quad[1];
    end
  end

  // --------------------------------------------------------------------------
  // Sine table, registered read
  // --------------------------------------------------------------------------
  logic [14:0] sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [14:0] ENTRY = sine_entry(k);
    assign sine_rom[k] = ENTRY;
  end

  logic [14:0] mag_r;
  logic        sign_r;

  always_ff @(posedge clk) begin
    if (en[S_ROM]) begin
      mag_r  <= sine_rom[addr_r];
      sign_r <= sign_a_r;
    end
  end

  // --------------------------------------------------------------------------
  // First multiplier level: u, v, u^2, v^2 and the sine wave channels
  // --------------------------------------------------------------------------
  logic [15:0] u_nxt;
  logic [15:0] v_nxt;
  logic [16:0] v_wide;
  logic [31:0] uu_full;
  logic [31:0] vv_full;
  logic [21:0] dr_full;
  logic [21:0] dg_full;
  logic [21:0] db_full;
  logic [7:0]  dr;
  logic [7:0]  dg;
  logic [7:0]  db;
  logic [23:0] p1_nxt;

  logic [15:0] u_m1_r;
  logic [15:0] v_m1_r;
  logic [15:0] uu_r;
  logic [15:0] vv_r;
  logic [23:0] p1_m1_r;

  always_comb begin
    // Negative half of the sine clamps to zero
    u_nxt   = HALF_Q16 + (sign_r ? 16'd0 : {1'b0, mag_r});
    v_wide  = 17'h10000 - {1'b0, u_nxt};
    v_nxt   = v_wide[15:0];
    uu_full = 32'(u_nxt) * 32'(u_nxt);
    vv_full = 32'(v_nxt) * 32'(v_nxt);
    // Sine wave palette: scaled magnitude truncated toward zero
    dr_full = 22'(mag_r) * P1_AMP_R;
    dg_full = 22'(mag_r) * P1_AMP_G;
    db_full = 22'(mag_r) * P1_AMP_B;
    dr      = {1'b0, dr_full[21:15]};
    dg      = {1'b0, dg_full[21:15]};
    db      = {1'b0, db_full[21:15]};
    p1_nxt  = {sign_r ? P1_BASE_R - dr : P1_BASE_R + dr,
               sign_r ? P1_BASE_G - dg : P1_BASE_G + dg,
               sign_r ? P1_BASE_B - db : P1_BASE_B + db};
  end

  always_ff @(posedge clk) begin
    if (en[S_M1]) begin
      u_m1_r  <= u_nxt;
      v_m1_r  <= v_nxt;
      uu_r    <= uu_full[31:16];
      vv_r    <= vv_full[31:16];
      p1_m1_r <= p1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Second multiplier level: u^3, v^3, v^2*u^2
  // --------------------------------------------------------------------------
  logic [31:0] uuu_full;
  logic [31:0] vvv_full;
  logic [31:0] pg_full;

  logic [15:0] u_m2_r;
  logic [15:0] v_m2_r;
  logic [15:0] uuu_r;
  logic [15:0] vvv_r;
  logic [15:0] pg_m2_r;
  logic [23:0] p1_m2_r;

  assign uuu_full = 32'(uu_r) * 32'(u_m1_r);
  assign vvv_full = 32'(vv_r) * 32'(v_m1_r);
  assign pg_full  = 32'(vv_r) * 32'(uu_r);

  always_ff @(posedge clk) begin
    if (en[S_M2]) begin
      u_m2_r  <= u_m1_r;
      v_m2_r  <= v_m1_r;
      uuu_r   <= uuu_full[31:16];
      vvv_r   <= vvv_full[31:16];
      pg_m2_r <= pg_full[31:16];
      p1_m2_r <= p1_m1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Third multiplier level: v*u^3 and v^3*u
  // --------------------------------------------------------------------------
  logic [31:0] pr_full;
  logic [31:0] pb_full;

  logic [15:0] pr_r;
  logic [15:0] pb_r;
  logic [15:0] pg_m3_r;
  logic [23:0] p1_m3_r;

  assign pr_full = 32'(v_m2_r) * 32'(uuu_r);
  assign pb_full = 32'(vvv_r) * 32'(u_m2_r);

  always_ff @(posedge clk) begin
    if (en[S_M3]) begin
      pr_r    <= pr_full[31:16];
      pb_r    <= pb_full[31:16];
      pg_m3_r <= pg_m2_r;
      p1_m3_r <= p1_m2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output: channel gains, offsets, clamp and pixel select
  // --------------------------------------------------------------------------
  logic [31:0] r_full;
  logic [31:0] g_full;
  logic [31:0] b_full;
  logic [15:0] r_sum;
  logic [15:0] g_sum;
  logic [15:0] b_sum;
  logic [7:0]  r8;
  logic [7:0]  g8;
  logic [7:0]  b8;
  logic [31:0] pix_nxt;
  logic [31:0] pix_r;

  always_comb begin
    r_full = 32'(pr_r) * 32'(P0_GAIN_R);
    g_full = 32'(pg_m3_r) * 32'(P0_GAIN_G);
    b_full = 32'(pb_r) * 32'(P0_GAIN_B);
    r_sum  = r_full[31:16] + P0_OFS_R;
    g_sum  = g_full[31:16];
    b_sum  = {1'b0, b_full[31:17]} + P0_OFS_B;
    r8     = (r_sum > 16'(CHAN_MAX)) ? CHAN_MAX : r_sum[7:0];
    g8     = (g_sum > 16'(CHAN_MAX)) ? CHAN_MAX : g_sum[7:0];
    b8     = (b_sum > 16'(CHAN_MAX)) ? CHAN_MAX : b_sum[7:0];
    if (int_r[S_M3]) begin
      pix_nxt = pal_r ? UV_INTERIOR : icolor_r;
    end else if (pal_r) begin
      pix_nxt = {p1_m3_r, ALPHA_OPAQUE};
    end else begin
      pix_nxt = {r8, g8, b8, ALPHA_OPAQUE};
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_tdata = pix_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ETCP_ASSERT_HOLDS(a_full_when_blocked, !in_tready, &vld_r,
                     "input blocked while a pipeline stage is empty")
  `ETCP_ASSERT_HOLDS(a_addr_range, vld_r[S_ADDR], addr_r <= AW'(SINE_TABLE_DEPTH),
                     "sine table address beyond the quarter wave")
  `ETCP_ASSERT_NEXT(a_no_repeat, out_tvalid && out_tready && !vld_r[S_OUT-1],
                    !out_tvalid, "pixel presented again after its transfer")

endmodule

// ===== bench/escape_time_color_palette_tb.sv =====
// ----------------------------------------------------------------------------
// Escape-time color palette testbench
// Streams iteration counts into the palette block and checks every RGBA pixel
// against a cycle-free predictor that rebuilds the quarter-wave sine table
// from its Taylor series. A directed table covers the interior cases, the
// zero and full-range limits, both palettes and an unmapped register write.
// Random segments follow, each with fresh register settings and its own
// idling on both stream sides, and one long output stall that backs up the
// pipeline.
// ----------------------------------------------------------------------------
module escape_time_color_palette_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etcp_pkg::*;

  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 16;
  localparam int SINE_DEPTH    = 1024;
  localparam int PIPE_LATENCY  = 15;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 5;
  localparam int LONG_STALL    = 300;
  localparam int SEGMENTS      = 10;
  localparam int SEG_ITEMS     = 93;
  localparam int CYCLE_LIMIT   = 200000;

  // Index that no register answers to
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  // One directed step: a count to send, or a register write
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] idx;
    logic [31:0]           value;
    logic                  typed;
    logic [31:0]           pixel;
  } row_t;

  localparam int DIRECTED_ROWS = 36;
  localparam row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    // Reset settings: limit 100, smooth palette, interior 0x000000FF
    '{ROW_PIXEL, 2'd0, 32'd0,     1'b1, 32'hB08C_EBFF},
    '{ROW_PIXEL, 2'd0, 32'd100,   1'b1, 32'h0000_00FF},
    '{ROW_PIXEL, 2'd0, 32'd65535, 1'b1, 32'h0000_00FF},
    '{ROW_PIXEL, 2'd0, 32'd99,    1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd50,    1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd1,     1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd33,    1'b0, 32'h0},
    // Zero limit: everything is interior
    '{ROW_WRITE, REG_INTERIOR,   32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_WRITE, REG_ITER_LIMIT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd0,      1'b1, 32'hFFFF_FFFF},
    '{ROW_PIXEL, 2'd0, 32'h0000_AAAA, 1'b1, 32'hFFFF_FFFF},
    // Full-range limit, upper write bits must be dropped
    '{ROW_WRITE, REG_ITER_LIMIT, 32'hABCD_FFFF, 1'b0, 32'h0},
    '{ROW_WRITE, REG_INTERIOR,   32'h0000_0000, 1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd65535,  1'b1, 32'h0000_0000},
    '{ROW_PIXEL, 2'd0, 32'd65534,  1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'h0000_5555, 1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd32767,  1'b0, 32'h0},
    // Sine wave palette
    '{ROW_WRITE, REG_PALETTE,    32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd65535,  1'b1, UV_INTERIOR},
    '{ROW_PIXEL, 2'd0, 32'd0,      1'b1, 32'h8040_C8FF},
    '{ROW_PIXEL, 2'd0, 32'd16384,  1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd49151,  1'b0, 32'h0},
    // Quadrant boundaries of the sine wave
    '{ROW_WRITE, REG_ITER_LIMIT, 32'd4, 1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd1,      1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd2,      1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd3,      1'b0, 32'h0},
    // Unmapped index leaves limit and palette alone
    '{ROW_WRITE, REG_UNMAPPED,   32'h0000_0000, 1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd3,      1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd4,      1'b1, UV_INTERIOR},
    // Smallest limit: only count zero is exterior
    '{ROW_WRITE, REG_ITER_LIMIT, 32'd1, 1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd0,      1'b1, 32'h8040_C8FF},
    '{ROW_PIXEL, 2'd0, 32'd1,      1'b1, UV_INTERIOR},
    '{ROW_WRITE, REG_PALETTE,    32'h0000_0000, 1'b0, 32'h0},
    '{ROW_PIXEL, 2'd0, 32'd0,      1'b1, 32'hB08C_EBFF},
    '{ROW_PIXEL, 2'd0, 32'd1,      1'b1, 32'h0000_0000},
    '{ROW_PIXEL, 2'd0, 32'd65535,  1'b1, 32'h0000_0000}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // in_tdata: [15:0] iteration_count
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata: [31:0] pixel_rgba
  logic [31:0]           out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow registers of the block
  logic [15:0] limit_r = ITER_LIMIT_RST;
  logic        palette_r = 1'b0;
  logic [31:0] interior_r = INTERIOR_RST;

  int          sine_tab [0:SINE_DEPTH];
  logic [31:0] pending_pixels [$];
  int          errors = 0;
  int          cycles = 0;
  int unsigned src_idle_pct = 14;
  int unsigned sink_idle_pct = 85;
  int unsigned stall_asks = 0;
  int unsigned stall_grants = 0;
  int unsigned stall_left = 0;

  escape_time_color_palette DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Quarter-wave entry k: Q30 Taylor series through x^11, rounded to Q1.15
  function automatic int quarter_sine_entry(int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned e;
    longint          sum;
    x = (64'(k) * HALF_PI_Q30) / 64'(SINE_DEPTH);
    term = x;
    sum = longint'(x);
    for (int unsigned n = 1; n <= 5; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n[0]) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    e = (longint'(sum) + 64'd16384) >> 15;
    if (e > 64'(SINE_MAX)) e = 64'(SINE_MAX);
    return int'(e);
  endfunction

  // Full-circle sine in Q1.15, a circle being 4*SINE_DEPTH steps
  function automatic int sine_at(longint unsigned phase);
    longint unsigned p;
    longint unsigned quad;
    longint unsigned ofs;
    int              mag;
    p = phase % 64'(4 * SINE_DEPTH);
    quad = p / 64'(SINE_DEPTH);
    ofs = p % 64'(SINE_DEPTH);
    mag = quad[0] ? sine_tab[SINE_DEPTH - int'(ofs)] : sine_tab[int'(ofs)];
    return (quad >= 2) ? -mag : mag;
  endfunction

  // w*amp in Q1.15, truncated toward zero
  function automatic int sine_swing(int w, int amp);
    int prod;
    prod = w * amp;
    return (prod < 0) ? -((-prod) >>> 15) : (prod >>> 15);
  endfunction

  function automatic logic [31:0] pack_rgb(longint r, longint g, longint b);
    logic [7:0] rc;
    logic [7:0] gc;
    logic [7:0] bc;
    rc = (r > 255) ? CHAN_MAX : 8'(r);
    gc = (g > 255) ? CHAN_MAX : 8'(g);
    bc = (b > 255) ? CHAN_MAX : 8'(b);
    return {rc, gc, bc, ALPHA_OPAQUE};
  endfunction

  // Pixel the block must produce for one count under the shadow settings
  function automatic logic [31:0] pixel_for_count(logic [15:0] count);
    longint unsigned t;
    longint unsigned u;
    longint unsigned v;
    longint unsigned uu;
    longint unsigned uuu;
    longint unsigned vv;
    longint unsigned vvv;
    longint unsigned pr;
    longint unsigned pg;
    longint unsigned pb;
    int              s;
    int              w;
    if (count >= limit_r) return palette_r ? UV_INTERIOR : interior_r;
    t = (64'(count) << FRACTION_BITS) / 64'(limit_r);
    if (!palette_r) begin
      s = sine_at((t * 2 * SINE_DEPTH) >> FRACTION_BITS);
      if (s < 0) s = 0;
      u = 64'(s) + 64'(HALF_Q16);
      v = 64'd65536 - u;
      uu = (u * u) >> 16;
      uuu = (uu * u) >> 16;
      vv = (v * v) >> 16;
      vvv = (vv * v) >> 16;
      pr = (v * uuu) >> 16;
      pg = (vv * uu) >> 16;
      pb = (vvv * u) >> 16;
      return pack_rgb(longint'(((64'(P0_GAIN_R) * pr) >> 16) + 64'(P0_OFS_R)),
                      longint'((64'(P0_GAIN_G) * pg) >> 16),
                      longint'(((64'(P0_GAIN_B) * pb) >> 17) + 64'(P0_OFS_B)));
    end
    w = sine_at((t * 4 * SINE_DEPTH) >> FRACTION_BITS);
    return pack_rgb(longint'(int'(P1_BASE_R) + sine_swing(w, int'(P1_AMP_R))),
                    longint'(int'(P1_BASE_G) + sine_swing(w, int'(P1_AMP_G))),
                    longint'(int'(P1_BASE_B) + sine_swing(w, int'(P1_AMP_B))));
  endfunction

  // Output side: check each pixel transfer, then pick the next tready
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none actual %08h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata !== want) begin
          $display("%0t: pixel_rgba mismatch, expected %08h actual %08h",
                   $time, want, out_tdata);
          errors++;
        end
      end
    end
    if (stall_asks != stall_grants) begin
      stall_grants = stall_asks;
      stall_left = LONG_STALL;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Offer one count, first idling at random with tvalid low; tvalid is left high after the transfer
  task automatic offer_count(input logic [15:0] count, input logic typed,
                             input logic [31:0] typed_pixel);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= count;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_pixels.push_back(typed ? typed_pixel : pixel_for_count(count));
  endtask

  // Drop tvalid and wait for the pipeline to empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ITER_LIMIT: limit_r = data[15:0];
      REG_PALETTE:    palette_r = data[0];
      REG_INTERIOR:   interior_r = data;
      default: ;
    endcase
  endtask

  initial begin
    logic [15:0] lim;
    logic        pal;
    logic [15:0] count;
    for (int k = 0; k <= SINE_DEPTH; k++) sine_tab[k] = quarter_sine_entry(k);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        settle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].value);
      end else begin
        offer_count(DIRECTED[i].value[15:0], DIRECTED[i].typed, DIRECTED[i].pixel);
      end
    end

    // Random segments, each with new settings
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      if (seg < 4) begin
        src_idle_pct = 14;
        sink_idle_pct <= 85;
      end else if (seg < 7) begin
        src_idle_pct = 85;
        sink_idle_pct <= 14;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct <= 0;
      end
      case (seg)
        0:       lim = ITER_LIMIT_RST;
        1, 5:    lim = 16'hFFFF;
        2:       lim = 16'($urandom_range(1, 16));
        4:       lim = 16'h0000;
        6:       lim = 16'($urandom_range(1, 1000));
        8:       lim = 16'd1;
        9:       lim = 16'($urandom_range(2, 300));
        default: lim = 16'($urandom_range(1, 65535));
      endcase
      pal = (seg == 1) ? 1'b0 : (seg == 5) ? 1'b1 : 1'($urandom_range(0, 1));
      write_reg(REG_ITER_LIMIT, {16'($urandom), lim});
      write_reg(REG_PALETTE, {31'($urandom), pal});
      write_reg(REG_INTERIOR, $urandom);
      if (seg == 3) write_reg(REG_UNMAPPED, $urandom);
      // Back up the pipeline while the sender keeps offering
      if (seg == 7) stall_asks <= stall_asks + 1;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (lim != 0 && $urandom_range(0, 9) < 8) count = 16'($urandom_range(0, lim - 1));
        else count = 16'($urandom_range(0, 65535));
        offer_count(count, 1'b0, 32'h0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
